// ===== hdl/clif_pkg.sv =====
// Shared types, constants and fixed-point helpers for the conductance LIF
// neuron update engine. Used by every module under hdl/ except clif_ram.
package clif_pkg;

  localparam int NEURONS  = 1024;
  localparam int ADDR_W   = $clog2(NEURONS);
  localparam int NEURON_W = 10;
  localparam int ADD_W    = 31;
  localparam int ONE_Q16  = 65536;

  localparam logic signed [31:0] V_REST  = -32'sd1174405;
  localparam logic signed [31:0] V_REV   = -32'sd1342177;
  localparam logic signed [31:0] V_ONSET = -32'sd1090519;
  localparam int                 SLOPE_W = 1006633;
  localparam logic [63:0]        SLOPE_W2 = 64'(SLOPE_W) * 64'(SLOPE_W);
  localparam logic [64:0]        OPEN_NUM = 65'(SLOPE_W2) << 16;

  // Pipeline stage numbers, counted from the accept cycle.
  localparam int ST_COND = 10;
  localparam int ST_OPEN = 23;
  localparam int ST_LAST = 31;

  localparam logic OP_STEP  = 1'b0;
  localparam logic OP_CLEAR = 1'b1;

  typedef enum logic [2:0] {
    CFG_DECAY_AMPA, CFG_DECAY_GABA, CFG_DECAY_THR, CFG_NMDA_RATE,
    CFG_MEMB_RATE, CFG_AMPA_SHARE, CFG_THR_REST, CFG_THR_JUMP
  } cfg_idx_t;

  typedef struct packed {
    logic [15:0]        decay_ampa;
    logic [15:0]        decay_gaba;
    logic [15:0]        decay_threshold;
    logic [15:0]        nmda_rate;
    logic [15:0]        membrane_rate;
    logic [15:0]        ampa_share;
    logic signed [31:0] threshold_rest;
    logic signed [31:0] threshold_jump;
  } cfg_t;

  typedef struct packed {
    logic signed [31:0] membrane;
    logic signed [31:0] thr_off;
    logic signed [31:0] ampa;
    logic signed [31:0] gaba;
    logic signed [31:0] nmda;
  } state_t;

  localparam state_t RESET_STATE = '{V_REST, 32'sd0, 32'sd0, 32'sd0, 32'sd0};

  typedef struct packed {
    logic                valid;
    logic                op;
    logic                in_range;
    logic [NEURON_W-1:0] neuron;
    logic signed [31:0]  v;
  } ctrl_t;

  typedef struct packed {
    logic signed [31:0] ga;
    logic signed [31:0] gg;
    logic signed [31:0] gn;
    logic signed [31:0] thr;
    logic signed [32:0] a_part;
    logic signed [32:0] n_part;
  } cond_t;

  typedef struct packed {
    logic               spiked;
    logic signed [31:0] vn;
    logic signed [31:0] thr;
  } memb_t;

  typedef struct packed {
    logic                spiked;
    logic [NEURON_W-1:0] neuron;
    logic signed [31:0]  membrane;
  } result_t;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
    logic signed [31:0] r;
    if (x > 64'sd2147483647) r = 32'sh7fffffff;
    else if (x < -64'sd2147483648) r = 32'sh80000000;
    else r = x[31:0];
    return r;
  endfunction

  // Round to nearest, halves up: floor((x + half) / 2^n).
  function automatic logic signed [63:0] rnd16(input logic signed [63:0] x);
    return (x + 64'sd32768) >>> 16;
  endfunction

  function automatic logic signed [63:0] rnd24(input logic signed [63:0] x);
    return (x + 64'sd8388608) >>> 24;
  endfunction

  function automatic logic signed [31:0] rnd_sat16(input logic signed [63:0] x);
    return sat32(rnd16(x));
  endfunction

endpackage

// ===== hdl/clif_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module clif_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hdl/clif_cond.sv =====
// Conductance path: increments, AMPA/GABA decay, NMDA relaxation, threshold
// decay and the two excitation weights. Depends on clif_pkg.
module clif_cond (
  input  logic                     clk,
  input  logic                     en,
  input  clif_pkg::cfg_t           cfg,
  input  clif_pkg::state_t         st,
  input  logic [clif_pkg::ADD_W-1:0] excite,
  input  logic [clif_pkg::ADD_W-1:0] inhibit,
  output clif_pkg::cond_t          cond
);
  import clif_pkg::*;

  logic signed [31:0] ga_s_r, gg_s_r, thr_s_r;
  logic signed [31:0] gn0_q [2:5];
  logic signed [48:0] ga_p_r, gg_p_r, thr_p_r;
  logic signed [31:0] ga_q [4:10];
  logic signed [31:0] gg_q [4:10];
  logic signed [31:0] thr_q [4:10];
  logic signed [48:0] pa_r, pn_r, as_r;
  logic signed [31:0] gn1_q [6:7];
  logic signed [31:0] gn_q [8:10];
  logic signed [49:0] ns_r;
  logic signed [32:0] a_part_r, n_part_r;
  logic [16:0]        share_n;

  assign share_n = 17'(ONE_Q16) - {1'b0, cfg.ampa_share};

  always_ff @(posedge clk) begin
    if (en) begin
      ga_s_r   <= sat32(64'($signed(st.ampa)) + $signed({33'd0, excite}));
      gg_s_r   <= sat32(64'($signed(st.gaba)) + $signed({33'd0, inhibit}));
      thr_s_r  <= st.thr_off;
      gn0_q[2] <= st.nmda;
      for (int k = 3; k <= 5; k++) gn0_q[k] <= gn0_q[k-1];

      ga_p_r  <= ga_s_r * $signed({1'b0, cfg.decay_ampa});
      gg_p_r  <= gg_s_r * $signed({1'b0, cfg.decay_gaba});
      thr_p_r <= thr_s_r * $signed({1'b0, cfg.decay_threshold});

      ga_q[4]  <= rnd_sat16(64'(ga_p_r));
      gg_q[4]  <= rnd_sat16(64'(gg_p_r));
      thr_q[4] <= rnd_sat16(64'(thr_p_r));
      for (int k = 5; k <= 10; k++) begin
        ga_q[k]  <= ga_q[k-1];
        gg_q[k]  <= gg_q[k-1];
        thr_q[k] <= thr_q[k-1];
      end

      // NMDA first follows AMPA, then relaxes by its own rate.
      pa_r     <= ga_q[4] * $signed({1'b0, cfg.nmda_rate});
      gn1_q[6] <= sat32(64'(gn0_q[5]) + rnd16(64'(pa_r)));
      gn1_q[7] <= gn1_q[6];
      pn_r     <= gn1_q[6] * $signed({1'b0, cfg.nmda_rate});
      gn_q[8]  <= sat32(64'(gn1_q[7]) - rnd16(64'(pn_r)));
      gn_q[9]  <= gn_q[8];
      gn_q[10] <= gn_q[9];

      as_r     <= ga_q[8] * $signed({1'b0, cfg.ampa_share});
      ns_r     <= gn_q[8] * $signed({1'b0, share_n});
      a_part_r <= 33'(rnd16(64'(as_r)));
      n_part_r <= 33'(rnd16(64'(ns_r)));
    end
  end

  assign cond.ga     = ga_q[10];
  assign cond.gg     = gg_q[10];
  assign cond.gn     = gn_q[10];
  assign cond.thr    = thr_q[10];
  assign cond.a_part = a_part_r;
  assign cond.n_part = n_part_r;

endmodule

// ===== hdl/clif_open.sv =====
// NMDA opening x^2/(1+x^2) in Q1.16, through a pipelined restoring divider
// that retires one quotient bit per stage. Depends on clif_pkg.
module clif_open (
  input  logic               clk,
  input  logic               en,
  input  logic signed [31:0] v,
  output logic [16:0]        open
);
  import clif_pkg::*;

  localparam int QB = 17;

  logic signed [32:0] d_r;
  logic               pos3_r, pos4_r;
  logic [63:0]        d2_r;
  logic [64:0]        den4_r;
  logic [64:0]        rem_q [QB+1];
  logic [64:0]        den_q [QB+1];
  logic [QB-1:0]      quo_q [QB+1];
  logic               pos_q [QB+1];
  logic [16:0]        open_r;
  logic [64:0]        rem_nxt [QB];
  logic [QB-1:0]      quo_nxt [QB];

  // One quotient bit per stage, most significant first.
  always_comb begin
    for (int i = 0; i < QB; i++) begin
      logic [81:0] trial;
      trial = {17'd0, den_q[i]} << (QB - 1 - i);
      rem_nxt[i] = rem_q[i];
      quo_nxt[i] = quo_q[i];
      if ({17'd0, rem_q[i]} >= trial) begin
        rem_nxt[i] = rem_q[i] - trial[64:0];
        quo_nxt[i][QB-1-i] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_r    <= 33'(v) - 33'(V_ONSET);
      pos3_r <= (d_r > 33'sd0);
      d2_r   <= 64'(d_r[31:0]) * 64'(d_r[31:0]);
      pos4_r <= pos3_r;
      den4_r <= 65'(d2_r) + 65'(SLOPE_W2);
      // Numerator carries half the divisor so the quotient rounds.
      rem_q[0] <= OPEN_NUM + (den4_r >> 1);
      den_q[0] <= den4_r;
      quo_q[0] <= '0;
      pos_q[0] <= pos4_r;
      for (int i = 0; i < QB; i++) begin
        rem_q[i+1] <= rem_nxt[i];
        den_q[i+1] <= den_q[i];
        quo_q[i+1] <= quo_nxt[i];
        pos_q[i+1] <= pos_q[i];
      end
      open_r <= pos_q[QB] ? (17'(ONE_Q16) - quo_q[QB]) : 17'd0;
    end
  end

  assign open = open_r;

endmodule

// ===== hdl/clif_memb.sv =====
// Membrane path: gain, drive, Euler step, clipping and the adaptive threshold
// check. Depends on clif_pkg.
module clif_memb (
  input  logic               clk,
  input  logic               en,
  input  clif_pkg::cfg_t     cfg,
  input  logic signed [31:0] v,
  input  clif_pkg::cond_t    cond,
  input  logic [16:0]        open,
  output clif_pkg::memb_t    res
);
  import clif_pkg::*;

  logic signed [31:0] v_q [24:29];
  logic signed [31:0] thr_q [24:30];
  logic signed [31:0] gg24_r, gg25_r;
  logic signed [32:0] a24_r;
  logic signed [50:0] np_r;
  logic signed [31:0] gain_r;
  logic signed [63:0] pg_r, pgg_r;
  logic signed [32:0] vr_r;
  logic signed [42:0] drive_r;
  logic signed [59:0] dvp_r;
  logic signed [43:0] dv_r;
  logic signed [31:0] vn_r, vs;
  logic signed [32:0] ths_r;
  memb_t              res_r;

  assign vs = sat32(64'(v_q[29]) + 64'(dv_r));

  always_ff @(posedge clk) begin
    if (en) begin
      v_q[24]   <= v;
      thr_q[24] <= cond.thr;
      for (int k = 25; k <= 29; k++) v_q[k] <= v_q[k-1];
      for (int k = 25; k <= 30; k++) thr_q[k] <= thr_q[k-1];
      gg24_r <= cond.gg;
      gg25_r <= gg24_r;
      a24_r  <= cond.a_part;
      np_r   <= cond.n_part * $signed({1'b0, open});

      gain_r <= sat32(64'(a24_r) + rnd16(64'(np_r)));

      pg_r  <= gain_r * v_q[25];
      pgg_r <= gg25_r * (33'(v_q[25]) - 33'(V_REV));
      vr_r  <= 33'(v_q[25]) - 33'(V_REST);

      drive_r <= 43'(-rnd24(pg_r) - rnd24(pgg_r) - 64'(vr_r));
      dvp_r   <= drive_r * $signed({1'b0, cfg.membrane_rate});
      dv_r    <= 44'(rnd16(64'(dvp_r)));

      vn_r  <= (vs < V_REV) ? V_REV : vs;
      ths_r <= 33'(cfg.threshold_rest) + 33'(thr_q[29]);

      res_r.spiked <= (33'(vn_r) > ths_r);
      res_r.vn     <= (33'(vn_r) > ths_r) ? V_REST : vn_r;
      res_r.thr    <= (33'(vn_r) > ths_r) ? cfg.threshold_jump : thr_q[30];
    end
  end

  assign res = res_r;

endmodule

// ===== hdl/conductance_lif_neuron_nmda_update.sv =====
// Top level of the conductance LIF neuron update engine: handshake, state
// RAM, hazard check, clearing pass and output buffer.
// Depends on clif_pkg, clif_ram, clif_cond, clif_open and clif_memb.
//
//  Channel  Direction  Transfer                 Payload
//  in_      slave      in_tvalid & in_tready    tuser: op; tdata: neuron,
//                                               excite_add, inhibit_add
//  out_     master     out_tvalid & out_tready  tuser: spiked; tdata:
//                                               neuron_out, membrane_out
//  cfg_     write      cfg_we                   cfg_addr, cfg_wdata
//
// One item per cycle enters a 31-stage pipeline when it is not stalled;
// the divider for the NMDA opening sets the depth, and the result is
// pushed into the output buffer from the last stage. An item whose neuron
// is still in the pipeline waits at the input until the earlier update is
// written back. After reset a clearing pass writes every neuron's state.
// A full two-entry output buffer freezes the whole pipeline.
module conductance_lif_neuron_nmda_update (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [71:0] in_tdata,   // neuron[9:0], excite_add[40:10], inhibit_add[71:41]
  input  logic        in_tuser,   // op
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // neuron_out[9:0], membrane_out[41:10], zero[47:42]
  output logic        out_tuser,  // spiked
  input  logic        cfg_we,
  input  logic [2:0]  cfg_addr,
  input  logic [31:0] cfg_wdata
);
  import clif_pkg::*;

  cfg_t                cfg_r;
  ctrl_t               ctrl_r [1:ST_LAST];
  ctrl_t               ctrl_in, ctrl_s2, fin;
  cond_t               cond_o;
  cond_t               cond_d [ST_COND+1:ST_LAST];
  memb_t               memb_o;
  state_t              ram_q, wr_data;
  logic [16:0]         open_o;
  logic [ADD_W-1:0]    ea_r, ia_r;
  logic [NEURON_W-1:0] in_neuron;
  logic                en, hazard, accept, leave;
  logic                ram_we;
  logic [ADDR_W-1:0]   ram_waddr;
  logic                clearing_r;
  logic [ADDR_W-1:0]   clr_cnt_r;
  logic [1:0]          fifo_cnt_r;
  result_t             fifo_q [2];
  result_t             push_item;
  logic                push, pop;

  assign in_neuron = in_tdata[9:0];
  assign en        = (fifo_cnt_r != 2'd2);

  always_comb begin
    hazard = 1'b0;
    for (int k = 1; k <= ST_LAST; k++) begin
      if (ctrl_r[k].valid && ctrl_r[k].neuron == in_neuron) hazard = 1'b1;
    end
  end

  assign in_tready = !clearing_r && en && !hazard;
  assign accept    = in_tvalid && in_tready;

  always_comb begin
    ctrl_in.valid    = accept;
    ctrl_in.op       = in_tuser;
    ctrl_in.in_range = (32'(in_neuron) < NEURONS);
    ctrl_in.neuron   = in_neuron;
    ctrl_in.v        = '0;
    ctrl_s2          = ctrl_r[1];
    ctrl_s2.v        = ram_q.membrane;
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.decay_ampa      <= 16'd64238;
      cfg_r.decay_gaba      <= 16'd64884;
      cfg_r.decay_threshold <= 16'd64238;
      cfg_r.nmda_rate       <= 16'd66;
      cfg_r.membrane_rate   <= 16'd328;
      cfg_r.ampa_share      <= 16'd32768;
      cfg_r.threshold_rest  <= -32'sd838861;
      cfg_r.threshold_jump  <= 32'sd1677722;
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_DECAY_AMPA: cfg_r.decay_ampa      <= cfg_wdata[15:0];
        CFG_DECAY_GABA: cfg_r.decay_gaba      <= cfg_wdata[15:0];
        CFG_DECAY_THR:  cfg_r.decay_threshold <= cfg_wdata[15:0];
        CFG_NMDA_RATE:  cfg_r.nmda_rate       <= cfg_wdata[15:0];
        CFG_MEMB_RATE:  cfg_r.membrane_rate   <= cfg_wdata[15:0];
        CFG_AMPA_SHARE: cfg_r.ampa_share      <= cfg_wdata[15:0];
        CFG_THR_REST:   cfg_r.threshold_rest  <= cfg_wdata;
        CFG_THR_JUMP:   cfg_r.threshold_jump  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Control pipeline; payload stages carry no reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 1; k <= ST_LAST; k++) ctrl_r[k].valid <= 1'b0;
    end else if (en) begin
      ctrl_r[1] <= ctrl_in;
      ctrl_r[2] <= ctrl_s2;
      for (int k = 3; k <= ST_LAST; k++) ctrl_r[k] <= ctrl_r[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ea_r <= in_tdata[40:10];
      ia_r <= in_tdata[71:41];
      cond_d[ST_COND+1] <= cond_o;
      for (int k = ST_COND + 2; k <= ST_LAST; k++) cond_d[k] <= cond_d[k-1];
    end
  end

  clif_ram #(.WIDTH($bits(state_t)), .DEPTH(NEURONS)) u_state (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (wr_data),
    .re    (en),
    .raddr (ADDR_W'(in_neuron)),
    .rdata (ram_q)
  );

  clif_cond u_cond (
    .clk     (clk),
    .en      (en),
    .cfg     (cfg_r),
    .st      (ram_q),
    .excite  (ea_r),
    .inhibit (ia_r),
    .cond    (cond_o)
  );

  clif_open u_open (
    .clk  (clk),
    .en   (en),
    .v    (ram_q.membrane),
    .open (open_o)
  );

  clif_memb u_memb (
    .clk  (clk),
    .en   (en),
    .cfg  (cfg_r),
    .v    (ctrl_r[ST_OPEN].v),
    .cond (cond_d[ST_OPEN]),
    .open (open_o),
    .res  (memb_o)
  );

  // Write-back and result formation at the last stage.
  assign fin   = ctrl_r[ST_LAST];
  assign leave = en && fin.valid;

  always_comb begin
    if (clearing_r) begin
      ram_we    = 1'b1;
      ram_waddr = clr_cnt_r;
      wr_data   = RESET_STATE;
    end else begin
      ram_we    = leave && fin.in_range;
      ram_waddr = ADDR_W'(fin.neuron);
      if (fin.op == OP_CLEAR) begin
        wr_data = RESET_STATE;
      end else begin
        wr_data = '{memb_o.vn, memb_o.thr, cond_d[ST_LAST].ga,
                    cond_d[ST_LAST].gg, cond_d[ST_LAST].gn};
      end
    end
    push_item.neuron   = fin.neuron;
    push_item.spiked   = fin.in_range && (fin.op == OP_STEP) && memb_o.spiked;
    if (!fin.in_range) push_item.membrane = '0;
    else if (fin.op == OP_CLEAR) push_item.membrane = V_REST;
    else push_item.membrane = memb_o.vn;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clearing_r <= 1'b1;
      clr_cnt_r  <= '0;
    end else if (clearing_r) begin
      if (clr_cnt_r == ADDR_W'(NEURONS - 1)) clearing_r <= 1'b0;
      else clr_cnt_r <= clr_cnt_r + 1'b1;
    end
  end

  // Two-entry output buffer; its registered fill level gates the pipeline.
  assign push = leave;
  assign pop  = out_tvalid && out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fifo_cnt_r <= 2'd0;
    end else begin
      case (fifo_cnt_r)
        2'd0: begin
          if (push) begin
            fifo_q[0]  <= push_item;
            fifo_cnt_r <= 2'd1;
          end
        end
        2'd1: begin
          if (push && pop) begin
            fifo_q[0] <= push_item;
          end else if (push) begin
            fifo_q[1]  <= push_item;
            fifo_cnt_r <= 2'd2;
          end else if (pop) begin
            fifo_cnt_r <= 2'd0;
          end
        end
        2'd2: begin
          if (pop) begin
            fifo_q[0]  <= fifo_q[1];
            fifo_cnt_r <= 2'd1;
          end
        end
        default: fifo_cnt_r <= 2'd0;
      endcase
    end
  end

  assign out_tvalid = (fifo_cnt_r != 2'd0);
  assign out_tuser  = fifo_q[0].spiked;
  assign out_tdata  = {6'd0, fifo_q[0].membrane, fifo_q[0].neuron};

  a_fifo_level: assert property (@(posedge clk) disable iff (!rst_n)
    fifo_cnt_r != 2'd3)
    else $error("output buffer level out of range");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable(ctrl_r[ST_LAST]))
    else $error("last stage moved while the pipeline was stalled");

  a_clear_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    clearing_r |-> (!out_tvalid && !ctrl_r[ST_LAST].valid))
    else $error("item in flight during the clearing pass");

endmodule
